// ===== rtl/core/yrc_pkg.sv =====
`timescale 1ns / 1ps

package yrc_pkg;

	localparam int COEF_W = 18;
	localparam int PROD_W = 28;
	localparam int PIX_W  = 8;

	localparam logic [1:0] REG_MATRIX = 2'd0;
	localparam logic [1:0] REG_METHOD = 2'd1;

	localparam logic [1:0] MATRIX_GENERIC = 2'd0;
	localparam logic [1:0] MATRIX_BT601   = 2'd1;
	localparam logic [1:0] MATRIX_BT709   = 2'd2;

	localparam logic [1:0] METHOD_PRECISE = 2'd0;
	localparam logic [1:0] METHOD_INT     = 2'd1;
	localparam logic [1:0] METHOD_TABLE   = 2'd2;

	typedef enum logic [1:0] {
		MODE_Q16,
		MODE_S8,
		MODE_TABLE
	} mode_t;

	typedef struct packed {
		logic [COEF_W-1:0] rv;
		logic [COEF_W-1:0] gu;
		logic [COEF_W-1:0] gv;
		logic [COEF_W-1:0] bu;
	} coef_t;

	typedef struct packed {
		mode_t            mode;
		logic [1:0]       matrix;
		logic [PIX_W-1:0] luma;
		logic [PIX_W-1:0] cb;
		logic [PIX_W-1:0] cr;
	} pix_t;

	typedef struct packed {
		mode_t                    mode;
		logic [PIX_W-1:0]         luma;
		logic signed [PROD_W-1:0] pr;
		logic signed [PROD_W-1:0] pgu;
		logic signed [PROD_W-1:0] pgv;
		logic signed [PROD_W-1:0] pb;
	} prod_t;

	// The unused method code behaves as the precise method.
	function automatic mode_t mode_decode(input logic [1:0] method);
		mode_t m;
		case (method)
			METHOD_INT:   m = MODE_S8;
			METHOD_TABLE: m = MODE_TABLE;
			default:      m = MODE_Q16;
		endcase
		return m;
	endfunction

	// The unused matrix code selects the generic set.
	function automatic coef_t coef_lookup(input logic [1:0] matrix, input mode_t mode);
		coef_t c;
		if (mode == MODE_Q16) begin
			case (matrix)
				MATRIX_BT601: c = '{18'd74700, 18'd25864, 18'd38050, 18'd133176};
				MATRIX_BT709: c = '{18'd83908, 18'd14078, 18'd24942, 18'd139459};
				default:      c = '{18'd89831, 18'd22127, 18'd45744, 18'd113538};
			endcase
		end else begin
			case (matrix)
				MATRIX_BT601: c = '{18'd292, 18'd101, 18'd149, 18'd520};
				MATRIX_BT709: c = '{18'd328, 18'd55, 18'd97, 18'd545};
				default:      c = '{18'd351, 18'd86, 18'd179, 18'd444};
			endcase
		end
		return c;
	endfunction

endpackage

// ===== rtl/core/yrc_product.sv =====
`timescale 1ns / 1ps

module yrc_product (
	input  logic          clk,
	input  logic          en,
	input  yrc_pkg::pix_t pix_s1,
	output yrc_pkg::prod_t prod_s2
);
	import yrc_pkg::*;

	coef_t                    k;
	logic signed [PIX_W-1:0]  u;
	logic signed [PIX_W-1:0]  v;
	prod_t                    prod_d;

	assign k = coef_lookup(pix_s1.matrix, pix_s1.mode);

	// Removing the offset of 128 from a byte is a flip of its top bit.
	assign u = $signed({~pix_s1.cb[PIX_W-1], pix_s1.cb[PIX_W-2:0]});
	assign v = $signed({~pix_s1.cr[PIX_W-1], pix_s1.cr[PIX_W-2:0]});

	always_comb begin
		prod_d.mode = pix_s1.mode;
		prod_d.luma = pix_s1.luma;
		prod_d.pr   = $signed({1'b0, k.rv}) * v;
		prod_d.pgu  = $signed({1'b0, k.gu}) * u;
		prod_d.pgv  = $signed({1'b0, k.gv}) * v;
		prod_d.pb   = $signed({1'b0, k.bu}) * u;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= prod_d;
		end
	end

endmodule

// ===== rtl/core/yrc_combine.sv =====
`timescale 1ns / 1ps

module yrc_combine (
	input  logic                      clk,
	input  logic                      en,
	input  yrc_pkg::prod_t            prod_s2,
	output logic [yrc_pkg::PIX_W-1:0] red,
	output logic [yrc_pkg::PIX_W-1:0] green,
	output logic [yrc_pkg::PIX_W-1:0] blue
);
	import yrc_pkg::*;

	logic signed [PROD_W-1:0] ys;
	logic signed [PROD_W-1:0] rs;
	logic signed [PROD_W-1:0] gs;
	logic signed [PROD_W-1:0] bs;
	logic [PIX_W-1:0]         red_s3;
	logic [PIX_W-1:0]         green_s3;
	logic [PIX_W-1:0]         blue_s3;

	// A negative sum gives zero under both truncation and floor, so only the
	// sign and the bits above the integer byte decide the clamp.
	function automatic logic [PIX_W-1:0] sat(input logic signed [PROD_W-1:0] s,
		input mode_t mode);
		logic [PIX_W-1:0] r;
		if (s[PROD_W-1]) begin
			r = '0;
		end else begin
			case (mode)
				MODE_S8:    r = (|s[PROD_W-2:16]) ? '1 : s[15:8];
				MODE_TABLE: r = (|s[PROD_W-2:8]) ? '1 : s[7:0];
				default:    r = (|s[PROD_W-2:24]) ? '1 : s[23:16];
			endcase
		end
		return r;
	endfunction

	always_comb begin
		case (prod_s2.mode)
			MODE_S8: begin
				ys = $signed({12'd0, prod_s2.luma, 8'd0});
				rs = ys + prod_s2.pr;
				gs = ys - prod_s2.pgu - prod_s2.pgv;
				bs = ys + prod_s2.pb;
			end
			MODE_TABLE: begin
				ys = $signed({20'd0, prod_s2.luma});
				rs = ys + (prod_s2.pr >>> 8);
				gs = ys - (prod_s2.pgu >>> 8) - (prod_s2.pgv >>> 8);
				bs = ys + (prod_s2.pb >>> 8);
			end
			default: begin
				ys = $signed({4'd0, prod_s2.luma, 16'd0});
				rs = ys + prod_s2.pr;
				gs = ys - prod_s2.pgu - prod_s2.pgv;
				bs = ys + prod_s2.pb;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red_s3   <= sat(rs, prod_s2.mode);
			green_s3 <= sat(gs, prod_s2.mode);
			blue_s3  <= sat(bs, prod_s2.mode);
		end
	end

	assign red   = red_s3;
	assign green = green_s3;
	assign blue  = blue_s3;

endmodule

// ===== rtl/core/yuv_to_rgb_pixel_converter.sv =====
`timescale 1ns / 1ps
// Converts one YCbCr pixel (luma, chroma_blue, chroma_red bytes) per transaction
// into clamped red, green and blue bytes.
// Input channel: in_valid / in_ready with luma, chroma_blue and chroma_red.
// Output channel: out_valid / out_ready with red, green and blue.
// Configuration channel: cfg_valid / cfg_ready with cfg_index and cfg_data.
// Index 0 selects the matrix (generic, BT.601, BT.709) and index 1 the method
// (Q16 precise, scaled sum, per-term table). cfg_ready is always high, and the
// registers must only be written while no pixel is in flight.
// The pipeline holds an input register, a product register holding the four
// coefficient products, and the result register that drives the outputs.
// Throughput is one pixel per cycle unless stalled; the four products are
// computed in parallel and the three sums and clamps share the final stage.
// When the receiver holds out_ready low with a result waiting, the whole
// pipeline stops and in_ready falls, so no transaction is lost; in_ready stays
// high while the output register is empty or being taken.
// Reset clears the pipeline valid bits and sets both registers to zero.
module yuv_to_rgb_pixel_converter (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [yrc_pkg::PIX_W-1:0] luma,
	input  logic [yrc_pkg::PIX_W-1:0] chroma_blue,
	input  logic [yrc_pkg::PIX_W-1:0] chroma_red,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [yrc_pkg::PIX_W-1:0] red,
	output logic [yrc_pkg::PIX_W-1:0] green,
	output logic [yrc_pkg::PIX_W-1:0] blue,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [1:0]                cfg_index,
	input  logic [1:0]                cfg_data
);
	import yrc_pkg::*;

	logic   [1:0] matrix_q;
	logic   [1:0] method_q;
	logic         adv;
	logic         valid_s1;
	logic         valid_s2;
	logic         valid_s3;
	pix_t         pix_s1;
	prod_t        prod_s2;

	assign cfg_ready = 1'b1;
	assign adv       = !valid_s3 || out_ready;
	assign in_ready  = adv;
	assign out_valid = valid_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_q <= MATRIX_GENERIC;
			method_q <= METHOD_PRECISE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MATRIX: matrix_q <= cfg_data;
				REG_METHOD: method_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s1.mode   <= mode_decode(method_q);
			pix_s1.matrix <= matrix_q;
			pix_s1.luma   <= luma;
			pix_s1.cb     <= chroma_blue;
			pix_s1.cr     <= chroma_red;
		end
	end

	yrc_product u_product (
		.clk     (clk),
		.en      (adv),
		.pix_s1  (pix_s1),
		.prod_s2 (prod_s2)
	);

	yrc_combine u_combine (
		.clk     (clk),
		.en      (adv),
		.prod_s2 (prod_s2),
		.red     (red),
		.green   (green),
		.blue    (blue)
	);

`ifndef NO_ASSERTIONS
	// An accepted transaction always lands in the input stage.
	a_accept_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> valid_s1)
		else $error("accepted pixel did not reach the input stage");

	// A stalled pipeline must neither drop nor advance a pending pixel.
	a_stall_holds_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !adv) |=> valid_s2)
		else $error("pixel lost in the product stage during a stall");

	// A product stage pixel moves into the result register when the pipe advances.
	a_s2_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && adv) |=> out_valid)
		else $error("product stage pixel did not reach the output");

	// The scaled sum method must decode into the scaled-by-256 datapath mode.
	a_mode_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && method_q == METHOD_INT) |=> pix_s1.mode == MODE_S8)
		else $error("method register decoded into the wrong datapath mode");
`endif

endmodule

// ===== tb/sv/tb_yuv_to_rgb_pixel_converter.sv =====
`timescale 1ns / 1ps

module tb_yuv_to_rgb_pixel_converter;

	import yrc_pkg::*;

	localparam logic [1:0] MATRIX_SPARE = 2'd3;
	localparam logic [1:0] METHOD_SPARE = 2'd3;
	localparam logic [1:0] REG_SPARE    = 2'd2;
	localparam int PIPE_DEPTH   = 3;
	localparam int RANDOM_ITEMS = 1650;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef struct packed {
		logic [1:0] matrix;
		logic [1:0] method;
		logic [7:0] y;
		logic [7:0] cb;
		logic [7:0] cr;
		logic       typed;
		rgb_t       want;
	} pixel_vec_t;

	localparam int NUM_DIRECTED = 24;
	localparam pixel_vec_t DIRECTED [0:NUM_DIRECTED-1] = '{
		'{MATRIX_GENERIC, METHOD_PRECISE, 8'd0,   8'd128, 8'd128, 1'b1, '{8'd0, 8'd0, 8'd0}},
		'{MATRIX_GENERIC, METHOD_PRECISE, 8'd255, 8'd128, 8'd128, 1'b1, '{8'd255, 8'd255, 8'd255}},
		'{MATRIX_GENERIC, METHOD_PRECISE, 8'd0,   8'd0,   8'd0,   1'b0, '{8'd0, 8'd0, 8'd0}},
		'{MATRIX_GENERIC, METHOD_PRECISE, 8'd255, 8'd255, 8'd255, 1'b0, '{8'd0, 8'd0, 8'd0}},
		'{MATRIX_GENERIC, METHOD_PRECISE, 8'd0,   8'd255, 8'd0,   1'b0, '{8'd0, 8'd0, 8'd0}},
		'{MATRIX_GENERIC, METHOD_PRECISE, 8'd255, 8'd0,   8'd255, 1'b0, '{8'd0, 8'd0, 8'd0}},
		'{MATRIX_GENERIC, METHOD_PRECISE, 8'd128, 8'd0,   8'd255, 1'b0, '{8'd0, 8'd0, 8'd0}},
		'{MATRIX_BT601,   METHOD_PRECISE, 8'd16,  8'd128, 8'd128, 1'b1, '{8'd16, 8'd16, 8'd16}},
		'{MATRIX_BT601,   METHOD_PRECISE, 8'd235, 8'd240, 8'd240, 1'b0, '{8'd0, 8'd0, 8'd0}},
		'{MATRIX_BT601,   METHOD_PRECISE, 8'd0,   8'd0,   8'd255, 1'b0, '{8'd0, 8'd0, 8'd0}},
		'{MATRIX_BT709,   METHOD_PRECISE, 8'd255, 8'd0,   8'd0,   1'b0, '{8'd0, 8'd0, 8'd0}},
		'{MATRIX_BT709,   METHOD_PRECISE, 8'd81,  8'd90,  8'd240, 1'b0, '{8'd0, 8'd0, 8'd0}},
		'{MATRIX_SPARE,   METHOD_PRECISE, 8'd255, 8'd255, 8'd0,   1'b0, '{8'd0, 8'd0, 8'd0}},
		'{MATRIX_GENERIC, METHOD_INT,     8'd0,   8'd0,   8'd0,   1'b0, '{8'd0, 8'd0, 8'd0}},
		'{MATRIX_GENERIC, METHOD_INT,     8'd255, 8'd255, 8'd255, 1'b0, '{8'd0, 8'd0, 8'd0}},
		'{MATRIX_GENERIC, METHOD_INT,     8'd128, 8'd128, 8'd128, 1'b1, '{8'd128, 8'd128, 8'd128}},
		'{MATRIX_BT709,   METHOD_INT,     8'd1,   8'd0,   8'd255, 1'b0, '{8'd0, 8'd0, 8'd0}},
		'{MATRIX_GENERIC, METHOD_TABLE,   8'd0,   8'd0,   8'd0,   1'b0, '{8'd0, 8'd0, 8'd0}},
		'{MATRIX_GENERIC, METHOD_TABLE,   8'd255, 8'd255, 8'd255, 1'b0, '{8'd0, 8'd0, 8'd0}},
		'{MATRIX_GENERIC, METHOD_TABLE,   8'd100, 8'd129, 8'd127, 1'b0, '{8'd0, 8'd0, 8'd0}},
		'{MATRIX_BT601,   METHOD_TABLE,   8'd200, 8'd10,  8'd250, 1'b0, '{8'd0, 8'd0, 8'd0}},
		'{MATRIX_SPARE,   METHOD_TABLE,   8'd0,   8'd255, 8'd255, 1'b0, '{8'd0, 8'd0, 8'd0}},
		'{MATRIX_GENERIC, METHOD_SPARE,   8'd0,   8'd0,   8'd255, 1'b0, '{8'd0, 8'd0, 8'd0}},
		'{MATRIX_BT709,   METHOD_SPARE,   8'd255, 8'd128, 8'd128, 1'b1, '{8'd255, 8'd255, 8'd255}}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] luma = 8'd0;
	logic [7:0] chroma_blue = 8'd0;
	logic [7:0] chroma_red = 8'd0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = 2'd0;
	logic [1:0] cfg_data = 2'd0;

	rgb_t       expected_rgb [$];
	logic [1:0] cur_matrix = MATRIX_GENERIC;
	logic [1:0] cur_method = METHOD_PRECISE;
	int         error_count = 0;
	int         stall_mode = 0;
	int         stall_left = 0;

	yuv_to_rgb_pixel_converter dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.luma       (luma),
		.chroma_blue(chroma_blue),
		.chroma_red (chroma_red),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [7:0] clamp_byte(input longint x);
		if (x < 0)
			return 8'd0;
		if (x > 255)
			return 8'd255;
		return x[7:0];
	endfunction

	function automatic rgb_t convert_pixel(input logic [7:0] y8, input logic [7:0] cb8,
			input logic [7:0] cr8, input logic [1:0] matrix, input logic [1:0] method);
		longint y, u, v, krv, kgu, kgv, kbu, r, g, b;
		rgb_t px;
		y = y8;
		u = cb8;
		v = cr8;
		u = u - 128;
		v = v - 128;
		if (method == METHOD_INT || method == METHOD_TABLE) begin
			case (matrix)
				MATRIX_BT601: begin krv = 292; kgu = 101; kgv = 149; kbu = 520; end
				MATRIX_BT709: begin krv = 328; kgu = 55; kgv = 97; kbu = 545; end
				default:      begin krv = 351; kgu = 86; kgv = 179; kbu = 444; end
			endcase
		end else begin
			case (matrix)
				MATRIX_BT601: begin krv = 74700; kgu = 25864; kgv = 38050; kbu = 133176; end
				MATRIX_BT709: begin krv = 83908; kgu = 14078; kgv = 24942; kbu = 139459; end
				default:      begin krv = 89831; kgu = 22127; kgv = 45744; kbu = 113538; end
			endcase
		end
		case (method)
			METHOD_INT: begin
				r = (256 * y + krv * v) >>> 8;
				g = (256 * y - kgu * u - kgv * v) >>> 8;
				b = (256 * y + kbu * u) >>> 8;
			end
			METHOD_TABLE: begin
				r = y + ((krv * v) >>> 8);
				g = y - ((kgu * u) >>> 8) - ((kgv * v) >>> 8);
				b = y + ((kbu * u) >>> 8);
			end
			default: begin
				// Signed division truncates toward zero.
				r = (65536 * y + krv * v) / 65536;
				g = (65536 * y - kgu * u - kgv * v) / 65536;
				b = (65536 * y + kbu * u) / 65536;
			end
		endcase
		px.red   = clamp_byte(r);
		px.green = clamp_byte(g);
		px.blue  = clamp_byte(b);
		return px;
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0:       return 8'd0;
			1:       return 8'd255;
			2:       return 8'd128;
			3:       return 8'($urandom_range(0, 3) + 126);
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic compare_channel(input string name, input logic [7:0] got,
			input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	task automatic send_pixel(input logic [7:0] y8, input logic [7:0] cb8, input logic [7:0] cr8,
			input logic typed, input rgb_t want);
		in_valid    <= 1'b1;
		luma        <= y8;
		chroma_blue <= cb8;
		chroma_red  <= cr8;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (typed)
			expected_rgb.push_back(want);
		else
			expected_rgb.push_back(convert_pixel(y8, cb8, cr8, cur_matrix, cur_method));
	endtask

	task automatic drain_pipeline();
		in_valid <= 1'b0;
		while (expected_rgb.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 2)
			@(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == REG_MATRIX)
			cur_matrix = val;
		else if (idx == REG_METHOD)
			cur_method = val;
	endtask

	task automatic apply_settings(input logic [1:0] matrix, input logic [1:0] method,
			input logic poke_spare);
		if (poke_spare)
			cfg_write(REG_SPARE | 2'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
		cfg_write(REG_MATRIX, matrix);
		cfg_write(REG_METHOD, method);
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(32, 256);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0:       out_ready <= 1'b1;
			1:       out_ready <= 1'($urandom_range(0, 1));
			2:       out_ready <= ($urandom_range(0, 7) != 0);
			default: out_ready <= (stall_left % 24 < 6);
		endcase
	end

	always @(posedge clk) begin : check_results
		rgb_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_rgb.size() == 0) begin
				report_mismatch("result transaction with no pixel pending");
			end else begin
				want = expected_rgb.pop_front();
				compare_channel("red", red, want.red);
				compare_channel("green", green, want.green);
				compare_channel("blue", blue, want.blue);
			end
		end
	end

	initial begin : stimulus
		int sent;
		int phase_len;
		int burst;
		int gap;
		rgb_t none;
		none = '0;
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_DIRECTED; i++) begin
			if (DIRECTED[i].matrix != cur_matrix || DIRECTED[i].method != cur_method) begin
				drain_pipeline();
				apply_settings(DIRECTED[i].matrix, DIRECTED[i].method, 1'b0);
			end
			send_pixel(DIRECTED[i].y, DIRECTED[i].cb, DIRECTED[i].cr, DIRECTED[i].typed,
				DIRECTED[i].want);
		end

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			drain_pipeline();
			apply_settings(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
				$urandom_range(0, 3) == 0);
			phase_len = $urandom_range(40, 160);
			while (phase_len > 0) begin
				burst = $urandom_range(1, 24);
				while (burst > 0 && phase_len > 0) begin
					send_pixel(pick_byte(), pick_byte(), pick_byte(), 1'b0, none);
					burst--;
					phase_len--;
					sent++;
				end
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				if (phase_len > 0 && gap > 0) begin
					in_valid <= 1'b0;
					repeat (gap)
						@(posedge clk);
				end
			end
		end

		drain_pipeline();
		if (error_count == 0 && expected_rgb.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
